/* design/source_byte_tokenizer_defines.svh */
// Assertion macros used by the checker file of the tokenizer.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define SBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SBT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sbt_pkg.sv */
// Shared types and constants of the source byte tokenizer.
// Used by the lexer, the token queue, the top level and the checker.
`default_nettype none

package sbt_pkg;

  localparam int DEFAULT_OFFSET_BITS = 24;
  localparam int DEFAULT_LINE_BITS   = 20;
  localparam int DEFAULT_COLUMN_BITS = 16;

  // Fixed widths of the token fields on the output channel.
  localparam int KIND_W       = 3;
  localparam int OFF_FIELD_W  = 24;
  localparam int LINE_FIELD_W = 20;
  localparam int COL_FIELD_W  = 16;
  localparam int S_TDATA_W    = 8;
  localparam int M_TDATA_W    = 88;

  // A byte can cause at most this many tokens.
  localparam int MAX_TOKENS = 3;

  // Token queue; the depth must be a power of two.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_EOF     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_KWINT   = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_DOT    = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KP_NONE    = 3'd0,
    KP_I       = 3'd1,
    KP_IN      = 3'd2,
    KP_INT     = 3'd3,
    KP_NOMATCH = 3'd4
  } kw_t;

  typedef struct packed {
    kind_t                   kind;
    logic [OFF_FIELD_W-1:0]  offset;
    logic [OFF_FIELD_W-1:0]  length;
    logic [LINE_FIELD_W-1:0] line;
    logic [COL_FIELD_W-1:0]  column;
    logic                    last;
  } token_t;

  // Tokens produced by one byte, in order, with a valid bit per slot.
  typedef struct packed {
    logic [MAX_TOKENS-1:0]           valid;
    token_t [MAX_TOKENS-1:0]         tok;
  } token_set_t;

endpackage

`default_nettype wire

/* design/source_byte_tokenizer.sv */
// Top level of the source byte tokenizer: stream ports, lexer and token queue.
// Depends on sbt_pkg, sbt_lexer and sbt_token_fifo.
//
// Usage: source bytes enter on the s_axis channel, one word per byte, with
// s_axis_tlast set on the last byte of a source. A zero byte also ends the
// source and is not counted. Tokens leave on the m_axis channel, one word
// per token; m_axis_tlast marks the final token caused by one input byte.
// A byte passes the input register before its tokens are queued. Throughput:
// one byte per cycle while s_axis_tready is high. A byte may cause up to
// three tokens (flushed token, unknown byte or token flushed at close, EOF);
// these drain at one per cycle from an eight-entry queue, and s_axis_tready
// drops while the queue lacks room for the work byte's tokens and three more.
// A stall on m_axis therefore backs up into s_axis after a few tokens; no
// token is lost or repeated. Reset empties the queue and the input register
// and sets offset 0, line 1, column 1 with no token pending.
`default_nettype none

module source_byte_tokenizer #(
  parameter int OFFSET_BITS = sbt_pkg::DEFAULT_OFFSET_BITS,
  parameter int LINE_BITS   = sbt_pkg::DEFAULT_LINE_BITS,
  parameter int COLUMN_BITS = sbt_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] src_byte
  input  logic [sbt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] token_kind, [26:3] start_offset, [50:27] token_length,
  // [70:51] start_line, [86:71] start_column, [87] zero
  output logic [sbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import sbt_pkg::*;

  logic                  busy;
  token_set_t            tokens;
  token_t                rd_tok;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign s_axis_tready = (int'(fifo_count) + (busy ? MAX_TOKENS : 0)) <=
                         (FIFO_DEPTH - MAX_TOKENS);

  sbt_lexer #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .in_load (s_axis_tvalid && s_axis_tready),
    .in_byte (s_axis_tdata),
    .in_end  (s_axis_tlast),
    .busy    (busy),
    .tokens  (tokens)
  );

  sbt_token_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (tokens),
    .rd_tok   (rd_tok),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .count    (fifo_count)
  );

  assign m_axis_tdata = {1'b0, rd_tok.column, rd_tok.line, rd_tok.length,
                         rd_tok.offset, rd_tok.kind};
  assign m_axis_tlast = rd_tok.last;

endmodule

`default_nettype wire

/* design/sbt_lexer.sv */
// Input register and single-pass token logic of the source byte tokenizer.
// Depends on sbt_pkg; feeds up to three tokens per byte to the token queue.
`default_nettype none

module sbt_lexer #(
  parameter int OFFSET_BITS = sbt_pkg::DEFAULT_OFFSET_BITS,
  parameter int LINE_BITS   = sbt_pkg::DEFAULT_LINE_BITS,
  parameter int COLUMN_BITS = sbt_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_load,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output logic               busy,
  output sbt_pkg::token_set_t tokens
);
  import sbt_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;

  // Lexer state.
  mode_t                  mode, mode_next;
  kw_t                    kp, kp_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [COLUMN_BITS-1:0] column_count, column_count_next;
  logic [OFFSET_BITS-1:0] start_off, start_off_next;
  logic [LINE_BITS-1:0]   start_line, start_line_next;
  logic [COLUMN_BITS-1:0] start_col, start_col_next;

  // State after the byte itself, before a possible close of the source.
  mode_t                  mode_a;
  kw_t                    kp_a;
  logic [OFFSET_BITS-1:0] off_a, start_off_a;
  logic [LINE_BITS-1:0]   line_a, start_line_a;
  logic [COLUMN_BITS-1:0] col_a, start_col_a;

  logic nz, b_blank, b_alpha, b_digit, b_dot;
  logic cont_tok, flush_a, unk_a, close, flush_b;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic kind_t kind_of(input mode_t m, input kw_t k);
    kind_t r;
    case (m)
      MODE_IDENT:  r = (k == KP_INT) ? KIND_KWINT : KIND_IDENT;
      MODE_NUMBER: r = KIND_NUMBER;
      default:     r = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic token_t pack_token(
    input kind_t                  k,
    input logic [OFFSET_BITS-1:0] off,
    input logic [OFF_FIELD_W-1:0] len,
    input logic [LINE_BITS-1:0]   ln,
    input logic [COLUMN_BITS-1:0] col
  );
    token_t t;
    t.kind   = k;
    t.offset = OFF_FIELD_W'(off);
    t.length = len;
    t.line   = LINE_FIELD_W'(ln);
    t.column = COL_FIELD_W'(col);
    t.last   = 1'b0;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= in_load;
    end
    if (in_load) begin
      hold_byte <= in_byte;
      hold_end  <= in_end;
    end
  end

  assign busy = hold_valid;

  assign nz      = hold_byte != CH_NUL;
  assign b_blank = hold_byte == CH_SPACE || hold_byte == CH_TAB ||
                   hold_byte == CH_CR || hold_byte == CH_LF;
  assign b_alpha = is_alpha(hold_byte);
  assign b_digit = is_digit(hold_byte);
  assign b_dot   = hold_byte == CH_DOT;

  assign cont_tok = (mode == MODE_IDENT && (b_alpha || b_digit)) ||
                    (mode == MODE_NUMBER && (b_digit || hold_byte == CH_UNDER)) ||
                    (mode == MODE_DOT && b_digit);
  assign flush_a  = nz && !cont_tok && mode != MODE_IDLE;
  assign unk_a    = nz && !cont_tok && !b_blank && !b_alpha && !b_dot;
  assign close    = !nz || hold_end;
  assign flush_b  = close && mode_a != MODE_IDLE;

  // Next state: the byte first, then a close of the source restarts everything.
  always_comb begin
    off_a = byte_offset;
    line_a = line_count;
    col_a = column_count;
    mode_a = mode;
    kp_a = kp;
    start_off_a = start_off;
    start_line_a = start_line;
    start_col_a = start_col;
    if (nz) begin
      if (!(&byte_offset)) off_a = byte_offset + OFFSET_BITS'(1);
      if (hold_byte == CH_LF) begin
        if (!(&line_count)) line_a = line_count + LINE_BITS'(1);
        col_a = COLUMN_BITS'(1);
      end else if (!(&column_count)) begin
        col_a = column_count + COLUMN_BITS'(1);
      end
      if (cont_tok) begin
        if (mode == MODE_IDENT) begin
          if (kp == KP_I && hold_byte == CH_N) kp_a = KP_IN;
          else if (kp == KP_IN && hold_byte == CH_T) kp_a = KP_INT;
          else kp_a = KP_NOMATCH;
        end else if (mode == MODE_DOT) begin
          mode_a = MODE_NUMBER;
        end
      end else begin
        mode_a = MODE_IDLE;
        kp_a = KP_NONE;
        if (b_alpha || b_dot) begin
          start_off_a = byte_offset;
          start_line_a = line_count;
          start_col_a = column_count;
          mode_a = b_alpha ? MODE_IDENT : MODE_DOT;
          if (b_alpha) kp_a = (hold_byte == CH_I) ? KP_I : KP_NOMATCH;
        end
      end
    end

    mode_next = mode;
    kp_next = kp;
    byte_offset_next = byte_offset;
    line_count_next = line_count;
    column_count_next = column_count;
    start_off_next = start_off;
    start_line_next = start_line;
    start_col_next = start_col;
    if (hold_valid) begin
      if (close) begin
        mode_next = MODE_IDLE;
        kp_next = KP_NONE;
        byte_offset_next = '0;
        line_count_next = LINE_BITS'(1);
        column_count_next = COLUMN_BITS'(1);
        start_off_next = '0;
        start_line_next = LINE_BITS'(1);
        start_col_next = COLUMN_BITS'(1);
      end else begin
        mode_next = mode_a;
        kp_next = kp_a;
        byte_offset_next = off_a;
        line_count_next = line_a;
        column_count_next = col_a;
        start_off_next = start_off_a;
        start_line_next = start_line_a;
        start_col_next = start_col_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      kp <= KP_NONE;
      byte_offset <= '0;
      line_count <= LINE_BITS'(1);
      column_count <= COLUMN_BITS'(1);
      start_off <= '0;
      start_line <= LINE_BITS'(1);
      start_col <= COLUMN_BITS'(1);
    end else begin
      mode <= mode_next;
      kp <= kp_next;
      byte_offset <= byte_offset_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      start_off <= start_off_next;
      start_line <= start_line_next;
      start_col <= start_col_next;
    end
  end

  // Token slots: the flushed token, then an unknown byte or the token flushed
  // at close, then EOF. The two middle cases never occur together.
  always_comb begin
    tokens.valid[0] = hold_valid && flush_a;
    tokens.valid[1] = hold_valid && (unk_a || flush_b);
    tokens.valid[2] = hold_valid && close;

    tokens.tok[0] = pack_token(kind_of(mode, kp), start_off,
                               (mode == MODE_DOT) ? OFF_FIELD_W'(1)
                                                  : OFF_FIELD_W'(byte_offset - start_off),
                               start_line, start_col);
    if (unk_a) begin
      tokens.tok[1] = pack_token(KIND_UNKNOWN, byte_offset, OFF_FIELD_W'(1),
                                 line_count, column_count);
    end else begin
      tokens.tok[1] = pack_token(kind_of(mode_a, kp_a), start_off_a,
                                 (mode_a == MODE_DOT) ? OFF_FIELD_W'(1)
                                                      : OFF_FIELD_W'(off_a - start_off_a),
                                 start_line_a, start_col_a);
    end
    tokens.tok[2] = pack_token(KIND_EOF, off_a, '0, line_a, col_a);

    tokens.tok[0].last = !tokens.valid[1] && !tokens.valid[2];
    tokens.tok[1].last = !tokens.valid[2];
    tokens.tok[2].last = 1'b1;
  end

endmodule

`default_nettype wire

/* design/sbt_token_fifo.sv */
// Token queue of the source byte tokenizer: takes up to three tokens per
// cycle in order and hands out one per cycle while rd_ready is high. Depends on sbt_pkg.
`default_nettype none

module sbt_token_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  sbt_pkg::token_set_t             wr,
  output sbt_pkg::token_t                 rd_tok,
  output logic                            rd_valid,
  input  logic                            rd_ready,
  output logic [sbt_pkg::FIFO_CNT_W-1:0]  count
);
  import sbt_pkg::*;

  token_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W-1:0] pos1, pos2;
  logic [FIFO_CNT_W-1:0] n_wr;
  logic                  pop;

  // Valid slots are packed down so that tokens land in order.
  assign pos1 = FIFO_PTR_W'(wr.valid[0]);
  assign pos2 = FIFO_PTR_W'(wr.valid[0]) + FIFO_PTR_W'(wr.valid[1]);
  assign n_wr = FIFO_CNT_W'(wr.valid[0]) + FIFO_CNT_W'(wr.valid[1]) +
                FIFO_CNT_W'(wr.valid[2]);
  assign pop  = rd_valid && rd_ready;

  assign rd_valid = count != '0;
  assign rd_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.valid[0]) mem[wr_ptr] <= wr.tok[0];
    if (wr.valid[1]) mem[wr_ptr + pos1] <= wr.tok[1];
    if (wr.valid[2]) mem[wr_ptr + pos2] <= wr.tok[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_wr);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count + n_wr - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/sbt_checker.sv */
// Port-level checks of the source byte tokenizer, bound to the top level.
// Depends on sbt_pkg and source_byte_tokenizer_defines.svh.
`default_nettype none
`include "source_byte_tokenizer_defines.svh"

module sbt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sbt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sbt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import sbt_pkg::*;

  // A stalled token word holds.
  `SBT_ASSERT(a_out_hold,
              m_axis_tvalid && !m_axis_tready |=>
                m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
              "token word changed while stalled")

  // EOF always closes the run of its byte and has no length.
  `SBT_ASSERT(a_eof_shape,
              m_axis_tvalid && m_axis_tdata[2:0] == KIND_EOF |->
                m_axis_tlast && m_axis_tdata[50:27] == '0,
              "malformed EOF token")

  // Line and column count from one.
  `SBT_ASSERT(a_pos_nonzero,
              m_axis_tvalid |-> m_axis_tdata[70:51] != '0 && m_axis_tdata[86:71] != '0,
              "token position is zero")

  // Nothing is offered in the cycle after a reset cycle.
  `SBT_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid, "token offered after reset")

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (.*);

`default_nettype wire
